// ----- hdl/lli3d_pkg.sv -----
package lli3d_pkg;

    // coordinate width actually used from each 16-bit input field
    localparam int COORD_W = 16;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 32;
    localparam int TOL_W   = 63;
    localparam int CFG_W   = 64;
    localparam int ADDR_W  = 4;

    // derived arithmetic widths
    localparam int D_W     = COORD_W + 1;       // direction differences
    localparam int P_W     = 2 * D_W;           // cross product partial products
    localparam int C_W     = P_W + 1;           // cross product terms
    localparam int T_W     = D_W + C_W + 2;     // triple product
    localparam int DEN_W   = 2 * C_W + 1;       // squared length and numerator dot
    localparam int NMAG_W  = 2 * C_W;           // numerator magnitude
    localparam int LO_W    = NMAG_W / 2;
    localparam int HI_W    = NMAG_W - LO_W;
    localparam int M_W     = D_W;               // direction magnitude
    localparam int N_W     = M_W + NMAG_W;      // dividend
    localparam int Q_W     = 40;                // quotient bits before saturation
    localparam int DIV_W   = DEN_W + Q_W;
    localparam int CMP_W   = 128;
    localparam int V_W     = Q_W + 2;

    // pipeline depth: eight arithmetic stages, overflow check, quotient bits, output
    localparam int NSTG    = Q_W + 10;

    // register indexes, taken from paddr[3]
    localparam logic REG_COPLANAR = 1'b0;
    localparam logic REG_PARALLEL = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_SKEW     = 2'd2
    } status_t;

    // data that travels alongside the divider stages
    typedef struct packed {
        status_t                   status;
        logic [DEN_W-1:0]          den;
        logic [2:0][COORD_W-1:0]   p1;
        logic [2:0]                neg;
    } side_t;

endpackage

// ----- hdl/line_line_intersection_3d_core.sv -----
// Intersection of two 3D lines, one pair of lines per transfer.
// Input channel s_*: twelve signed Q12.4 coordinates (start and end point
// of line a and of line b). Result channel m_*: hit_x/y/z in signed Q28.4,
// saturated, and a status (0 intersect, 1 parallel, 2 skew); the point is
// zero unless the lines intersect.
// Throughput: one transfer per cycle while the result side is not stalled.
// The pipeline is made of the eight multiply and sum stages, one
// overflow check stage, one stage per quotient bit of the 40-bit
// restoring divider and the output register.
// The whole pipeline advances together; while a result waits and m_ready
// is low, s_ready is low and every stage holds, so nothing is lost or
// repeated. Bubbles move through at full rate.
// APB port: coplanar tolerance at address 0, parallel tolerance at 8,
// 63 bits each in a 64-bit word; write them only while the block is idle.
// Synchronous active-low reset on aresetn empties the pipeline and sets
// both tolerances to 1.
module line_line_intersection_3d_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_a_start_x,
    input  logic signed [15:0]            s_a_start_y,
    input  logic signed [15:0]            s_a_start_z,
    input  logic signed [15:0]            s_a_end_x,
    input  logic signed [15:0]            s_a_end_y,
    input  logic signed [15:0]            s_a_end_z,
    input  logic signed [15:0]            s_b_start_x,
    input  logic signed [15:0]            s_b_start_y,
    input  logic signed [15:0]            s_b_start_z,
    input  logic signed [15:0]            s_b_end_x,
    input  logic signed [15:0]            s_b_end_y,
    input  logic signed [15:0]            s_b_end_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_hit_x,
    output logic signed [31:0]            m_hit_y,
    output logic signed [31:0]            m_hit_z,
    output logic [1:0]                    m_status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lli3d_pkg::ADDR_W-1:0]  paddr,
    input  logic [lli3d_pkg::CFG_W-1:0]   pwdata,
    output logic [lli3d_pkg::CFG_W-1:0]   prdata,
    output logic                          pready
);

    localparam int COORD_W = lli3d_pkg::COORD_W;
    localparam int D_W     = lli3d_pkg::D_W;
    localparam int P_W     = lli3d_pkg::P_W;
    localparam int C_W     = lli3d_pkg::C_W;
    localparam int T_W     = lli3d_pkg::T_W;
    localparam int DEN_W   = lli3d_pkg::DEN_W;
    localparam int NMAG_W  = lli3d_pkg::NMAG_W;
    localparam int LO_W    = lli3d_pkg::LO_W;
    localparam int HI_W    = lli3d_pkg::HI_W;
    localparam int M_W     = lli3d_pkg::M_W;
    localparam int N_W     = lli3d_pkg::N_W;
    localparam int Q_W     = lli3d_pkg::Q_W;
    localparam int DIV_W   = lli3d_pkg::DIV_W;
    localparam int CMP_W   = lli3d_pkg::CMP_W;
    localparam int V_W     = lli3d_pkg::V_W;
    localparam int OUT_W   = lli3d_pkg::OUT_W;
    localparam int TOL_W   = lli3d_pkg::TOL_W;
    localparam int NSTG    = lli3d_pkg::NSTG;

    localparam logic signed [V_W-1:0] OUT_MAX = V_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [V_W-1:0] OUT_MIN = -V_W'(64'sd1 <<< (OUT_W - 1));

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [TOL_W-1:0] cop_tol_reg;
    logic [TOL_W-1:0] par_tol_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cop_tol_reg <= TOL_W'(1);
            par_tol_reg <= TOL_W'(1);
        end else if (cfg_wr) begin
            case (paddr[3])
                lli3d_pkg::REG_COPLANAR: cop_tol_reg <= pwdata[TOL_W-1:0];
                lli3d_pkg::REG_PARALLEL: par_tol_reg <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[3])
            lli3d_pkg::REG_COPLANAR: prdata = {1'b0, cop_tol_reg};
            lli3d_pkg::REG_PARALLEL: prdata = {1'b0, par_tol_reg};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: all stages advance together
    // ------------------------------------------------------------------
    logic            adv;
    logic [NSTG-1:0] vld_reg;

    assign adv     = !vld_reg[NSTG-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: direction vectors
    // ------------------------------------------------------------------
    logic [2:0][COORD_W-1:0] a0, a1, b0, b1;
    logic [2:0][D_W-1:0]     d1_next, d2_next, d3_next;
    logic [2:0][COORD_W-1:0] s1_p1_reg;
    logic [2:0][D_W-1:0]     s1_d1_reg, s1_d2_reg, s1_d3_reg;

    assign a0 = {s_a_start_z[COORD_W-1:0], s_a_start_y[COORD_W-1:0], s_a_start_x[COORD_W-1:0]};
    assign a1 = {s_a_end_z[COORD_W-1:0], s_a_end_y[COORD_W-1:0], s_a_end_x[COORD_W-1:0]};
    assign b0 = {s_b_start_z[COORD_W-1:0], s_b_start_y[COORD_W-1:0], s_b_start_x[COORD_W-1:0]};
    assign b1 = {s_b_end_z[COORD_W-1:0], s_b_end_y[COORD_W-1:0], s_b_end_x[COORD_W-1:0]};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d1_next[i] = D_W'($signed(a1[i])) - D_W'($signed(a0[i]));
            d2_next[i] = D_W'($signed(b1[i])) - D_W'($signed(b0[i]));
            d3_next[i] = D_W'($signed(b0[i])) - D_W'($signed(a0[i]));
        end
    end

    // ------------------------------------------------------------------
    // stage 2: cross product partial products for c = d1 x d2, e = d3 x d2
    // ------------------------------------------------------------------
    logic [2:0][P_W-1:0]     pca_next, pcb_next, pea_next, peb_next;
    logic [2:0][P_W-1:0]     s2_pca_reg, s2_pcb_reg, s2_pea_reg, s2_peb_reg;
    logic [2:0][D_W-1:0]     s2_d1_reg, s2_d3_reg;
    logic [2:0][COORD_W-1:0] s2_p1_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pca_next[i] = P_W'($signed(s1_d1_reg[(i+1)%3])) * P_W'($signed(s1_d2_reg[(i+2)%3]));
            pcb_next[i] = P_W'($signed(s1_d1_reg[(i+2)%3])) * P_W'($signed(s1_d2_reg[(i+1)%3]));
            pea_next[i] = P_W'($signed(s1_d3_reg[(i+1)%3])) * P_W'($signed(s1_d2_reg[(i+2)%3]));
            peb_next[i] = P_W'($signed(s1_d3_reg[(i+2)%3])) * P_W'($signed(s1_d2_reg[(i+1)%3]));
        end
    end

    // ------------------------------------------------------------------
    // stage 3: cross product terms
    // ------------------------------------------------------------------
    logic [2:0][C_W-1:0]     c_next, e_next;
    logic [2:0][C_W-1:0]     s3_c_reg, s3_e_reg;
    logic [2:0][D_W-1:0]     s3_d1_reg, s3_d3_reg;
    logic [2:0][COORD_W-1:0] s3_p1_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_next[i] = C_W'($signed(s2_pca_reg[i])) - C_W'($signed(s2_pcb_reg[i]));
            e_next[i] = C_W'($signed(s2_pea_reg[i])) - C_W'($signed(s2_peb_reg[i]));
        end
    end

    // ------------------------------------------------------------------
    // stage 4: dot product terms
    // ------------------------------------------------------------------
    logic [2:0][T_W-1:0]     tp_next;
    logic [2:0][DEN_W-1:0]   dp_next, np_next;
    logic [2:0][T_W-1:0]     s4_tp_reg;
    logic [2:0][DEN_W-1:0]   s4_dp_reg, s4_np_reg;
    logic [2:0][D_W-1:0]     s4_d1_reg;
    logic [2:0][COORD_W-1:0] s4_p1_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tp_next[i] = T_W'($signed(s3_d3_reg[i])) * T_W'($signed(s3_c_reg[i]));
            dp_next[i] = DEN_W'($signed(s3_c_reg[i])) * DEN_W'($signed(s3_c_reg[i]));
            np_next[i] = DEN_W'($signed(s3_e_reg[i])) * DEN_W'($signed(s3_c_reg[i]));
        end
    end

    // ------------------------------------------------------------------
    // stage 5: dot product sums
    // ------------------------------------------------------------------
    logic [T_W-1:0]          trip_next;
    logic [DEN_W-1:0]        den_next, num_next;
    logic [T_W-1:0]          s5_trip_reg;
    logic [DEN_W-1:0]        s5_den_reg, s5_num_reg;
    logic [2:0][D_W-1:0]     s5_d1_reg;
    logic [2:0][COORD_W-1:0] s5_p1_reg;

    assign trip_next = s4_tp_reg[0] + s4_tp_reg[1] + s4_tp_reg[2];
    assign den_next  = s4_dp_reg[0] + s4_dp_reg[1] + s4_dp_reg[2];
    assign num_next  = s4_np_reg[0] + s4_np_reg[1] + s4_np_reg[2];

    // ------------------------------------------------------------------
    // stage 6: classify, take magnitudes and signs
    // ------------------------------------------------------------------
    logic [T_W-1:0]          trip_mag;
    logic [NMAG_W-1:0]       nmag_next;
    logic [2:0][M_W-1:0]     d1mag_next;
    logic [2:0]              neg_next;
    lli3d_pkg::status_t      status_next;
    logic [NMAG_W-1:0]       s6_nmag_reg;
    logic [2:0][M_W-1:0]     s6_d1mag_reg;
    lli3d_pkg::side_t        s6_side_reg;

    always_comb begin
        trip_mag  = s5_trip_reg[T_W-1] ? (T_W'(0) - s5_trip_reg) : s5_trip_reg;
        nmag_next = s5_num_reg[DEN_W-1] ? NMAG_W'(DEN_W'(0) - s5_num_reg)
                                        : NMAG_W'(s5_num_reg);
        for (int i = 0; i < 3; i++) begin
            d1mag_next[i] = s5_d1_reg[i][D_W-1] ? (D_W'(0) - s5_d1_reg[i]) : s5_d1_reg[i];
            neg_next[i]   = s5_d1_reg[i][D_W-1] ^ s5_num_reg[DEN_W-1];
        end
        if (!(CMP_W'(trip_mag) < CMP_W'(cop_tol_reg))) begin
            status_next = lli3d_pkg::ST_SKEW;
        end else if ((CMP_W'(s5_den_reg) < CMP_W'(par_tol_reg)) || (s5_den_reg == '0)) begin
            status_next = lli3d_pkg::ST_PARALLEL;
        end else begin
            status_next = lli3d_pkg::ST_HIT;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: dividend partial products |d1| * |num|
    // ------------------------------------------------------------------
    logic [2:0][M_W+LO_W-1:0] pl_next;
    logic [2:0][M_W+HI_W-1:0] ph_next;
    logic [2:0][M_W+LO_W-1:0] s7_pl_reg;
    logic [2:0][M_W+HI_W-1:0] s7_ph_reg;
    lli3d_pkg::side_t         s7_side_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pl_next[i] = (M_W+LO_W)'(s6_d1mag_reg[i]) * (M_W+LO_W)'(s6_nmag_reg[LO_W-1:0]);
            ph_next[i] = (M_W+HI_W)'(s6_d1mag_reg[i]) * (M_W+HI_W)'(s6_nmag_reg[NMAG_W-1:LO_W]);
        end
    end

    // ------------------------------------------------------------------
    // stage 8: assemble dividend
    // ------------------------------------------------------------------
    logic [2:0][N_W-1:0]     n_next;
    logic [2:0][N_W-1:0]     s8_n_reg;
    lli3d_pkg::side_t        s8_side_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_next[i] = N_W'(s7_pl_reg[i]) + (N_W'(s7_ph_reg[i]) << LO_W);
        end
    end

    // hold or advance stages 1 to 8
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_p1_reg    <= a0;
            s1_d1_reg    <= d1_next;
            s1_d2_reg    <= d2_next;
            s1_d3_reg    <= d3_next;

            s2_pca_reg   <= pca_next;
            s2_pcb_reg   <= pcb_next;
            s2_pea_reg   <= pea_next;
            s2_peb_reg   <= peb_next;
            s2_d1_reg    <= s1_d1_reg;
            s2_d3_reg    <= s1_d3_reg;
            s2_p1_reg    <= s1_p1_reg;

            s3_c_reg     <= c_next;
            s3_e_reg     <= e_next;
            s3_d1_reg    <= s2_d1_reg;
            s3_d3_reg    <= s2_d3_reg;
            s3_p1_reg    <= s2_p1_reg;

            s4_tp_reg    <= tp_next;
            s4_dp_reg    <= dp_next;
            s4_np_reg    <= np_next;
            s4_d1_reg    <= s3_d1_reg;
            s4_p1_reg    <= s3_p1_reg;

            s5_trip_reg  <= trip_next;
            s5_den_reg   <= den_next;
            s5_num_reg   <= num_next;
            s5_d1_reg    <= s4_d1_reg;
            s5_p1_reg    <= s4_p1_reg;

            s6_nmag_reg        <= nmag_next;
            s6_d1mag_reg       <= d1mag_next;
            s6_side_reg.status <= status_next;
            s6_side_reg.den    <= s5_den_reg;
            s6_side_reg.p1     <= s5_p1_reg;
            s6_side_reg.neg    <= neg_next;

            s7_pl_reg    <= pl_next;
            s7_ph_reg    <= ph_next;
            s7_side_reg  <= s6_side_reg;

            s8_n_reg     <= n_next;
            s8_side_reg  <= s7_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // divider: overflow check, then one quotient bit per stage
    // ------------------------------------------------------------------
    logic [2:0][N_W-1:0]  dv_rem_reg  [Q_W+1];
    logic [2:0][Q_W-1:0]  dv_quo_reg  [Q_W+1];
    logic [2:0]           dv_sat_reg  [Q_W+1];
    lli3d_pkg::side_t     dv_side_reg [Q_W+1];
    logic [2:0]           sat_next;
    logic [DIV_W-1:0]     den_top;

    assign den_top = DIV_W'(s8_side_reg.den) << Q_W;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat_next[i] = DIV_W'(s8_n_reg[i]) >= den_top;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0]  <= s8_n_reg;
            dv_quo_reg[0]  <= '0;
            dv_sat_reg[0]  <= sat_next;
            dv_side_reg[0] <= s8_side_reg;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        localparam int SH = Q_W - 1 - k;
        logic [DIV_W-1:0]    trial;
        logic [2:0][N_W-1:0] rem_next;
        logic [2:0][Q_W-1:0] quo_next;

        assign trial = DIV_W'(dv_side_reg[k].den) << SH;

        // trial subtract of the shifted divisor
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rem_next[i] = dv_rem_reg[k][i];
                quo_next[i] = dv_quo_reg[k][i];
                if (DIV_W'(dv_rem_reg[k][i]) >= trial) begin
                    rem_next[i]     = N_W'(DIV_W'(dv_rem_reg[k][i]) - trial);
                    quo_next[i][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[k+1]  <= rem_next;
                dv_quo_reg[k+1]  <= quo_next;
                dv_sat_reg[k+1]  <= dv_sat_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: apply sign, add start point, saturate
    // ------------------------------------------------------------------
    logic [2:0][OUT_W-1:0] hit_next;
    logic [2:0][OUT_W-1:0] hit_reg;
    logic [1:0]            status_reg;
    lli3d_pkg::side_t      fin;

    assign fin = dv_side_reg[Q_W];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [V_W-1:0] qv;
            logic signed [V_W-1:0] sum;
            qv  = $signed(V_W'(dv_quo_reg[Q_W][i]));
            sum = V_W'($signed(fin.p1[i])) + (fin.neg[i] ? -qv : qv);
            if (fin.status != lli3d_pkg::ST_HIT) begin
                hit_next[i] = '0;
            end else if (dv_sat_reg[Q_W][i]) begin
                hit_next[i] = fin.neg[i] ? OUT_W'(OUT_MIN) : OUT_W'(OUT_MAX);
            end else if (sum > OUT_MAX) begin
                hit_next[i] = OUT_W'(OUT_MAX);
            end else if (sum < OUT_MIN) begin
                hit_next[i] = OUT_W'(OUT_MIN);
            end else begin
                hit_next[i] = OUT_W'(sum);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg    <= hit_next;
            status_reg <= fin.status;
        end
    end

    assign m_hit_x  = $signed(hit_reg[0]);
    assign m_hit_y  = $signed(hit_reg[1]);
    assign m_hit_z  = $signed(hit_reg[2]);
    assign m_status = status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_hit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != lli3d_pkg::ST_HIT) |->
            (m_hit_x == 0) && (m_hit_y == 0) && (m_hit_z == 0))
        else $error("point not zero for parallel or skew result");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == lli3d_pkg::ST_HIT) || (m_status == lli3d_pkg::ST_PARALLEL)
                    || (m_status == lli3d_pkg::ST_SKEW))
        else $error("reserved status code on result");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipeline stalled");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && (m_status == $past(m_status)))
        else $error("stalled result dropped or changed");

endmodule
